// ===== rtl/pcp_pkg.sv =====
`default_nettype none

package pcp_pkg;

    // Pool geometry
    localparam int NUM_PIPES  = 16;
    localparam int RING_BYTES = 1024;
    localparam int MAX_READ   = 64;

    // Transaction field widths
    localparam int ACTION_W = 3;
    localparam int PIPE_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int RLEN_W   = 7;
    localparam int STATUS_W = 3;

    // Derived widths
    localparam int SLOT_W    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int POS_W     = $clog2(RING_BYTES);
    localparam int FILL_W    = $clog2(RING_BYTES + 1);
    localparam int LEN_W     = $clog2(MAX_READ + 1);
    localparam int MEM_AW    = SLOT_W + POS_W;
    localparam int MEM_DEPTH = NUM_PIPES * (2 ** POS_W);

    // Command queue and result queue depths (powers of two)
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_CREATE   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_READ     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLOSE_RD = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLOSE_WR = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EOS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCK  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BROKEN = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE   = 3'd6;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [LEN_W-1:0]  t_len;

    // Command kind after front-end decode
    typedef enum logic [2:0] {
        K_CREATE,
        K_WRITE,
        K_READ,
        K_CLOSE_RD,
        K_CLOSE_WR,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        t_slot             slot;
        logic [BYTE_W-1:0] wbyte;
        t_len              len;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   read_byte;
        logic [PIPE_W-1:0]   created_pipe;
        logic                last;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/pcp_if.sv =====
`default_nettype none

// Request channel
interface pcp_req_if import pcp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PIPE_W-1:0]   pipe_index;
    logic [BYTE_W-1:0]   write_byte;
    logic [RLEN_W-1:0]   read_length;

    modport source (output valid, action, pipe_index, write_byte, read_length,
                    input ready);
    modport sink   (input valid, action, pipe_index, write_byte, read_length,
                    output ready);
endinterface

// Result channel
interface pcp_rsp_if import pcp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   read_byte;
    logic [PIPE_W-1:0]   created_pipe;
    logic                last;

    modport source (output valid, status, read_byte, created_pipe, last,
                    input ready);
    modport sink   (input valid, status, read_byte, created_pipe, last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pcp_front.sv =====
`default_nettype none

module pcp_front import pcp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pcp_req_if.sink    i_req,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid,
    input  wire logic  i_cmd_ready
);

    t_cmd             r_q [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wp;
    logic [CQ_AW-1:0] r_rp;
    logic [CQ_CW-1:0] r_cnt;

    t_cmd n_cmd;
    logic idx_ok;
    logic push;
    logic pop;

    assign i_req.ready = (r_cnt != CQ_CW'(CQ_DEPTH));
    assign push        = i_req.valid & i_req.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid & i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Decode the transaction into a command; static range checks happen here
    always_comb begin
        idx_ok      = (32'(i_req.pipe_index) < NUM_PIPES);
        n_cmd.slot  = t_slot'(i_req.pipe_index);
        n_cmd.wbyte = i_req.write_byte;
        if (i_req.read_length == '0) begin
            n_cmd.len = LEN_W'(1);
        end else if (32'(i_req.read_length) > MAX_READ) begin
            n_cmd.len = LEN_W'(MAX_READ);
        end else begin
            n_cmd.len = LEN_W'(i_req.read_length);
        end
        unique case (i_req.action)
            ACT_CREATE:   n_cmd.kind = K_CREATE;
            ACT_WRITE:    n_cmd.kind = idx_ok ? K_WRITE    : K_BAD;
            ACT_READ:     n_cmd.kind = idx_ok ? K_READ     : K_BAD;
            ACT_CLOSE_RD: n_cmd.kind = idx_ok ? K_CLOSE_RD : K_BAD;
            ACT_CLOSE_WR: n_cmd.kind = idx_ok ? K_CLOSE_WR : K_BAD;
            default:      n_cmd.kind = K_BAD;
        endcase
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + CQ_AW'(1);
            if (pop)  r_rp <= r_rp + CQ_AW'(1);
            r_cnt <= r_cnt + CQ_CW'(push) - CQ_CW'(pop);
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
    end

endmodule

`default_nettype wire

// ===== rtl/pcp_back.sv =====
`default_nettype none

module pcp_back import pcp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_cmd_valid,
    output logic       o_cmd_ready,
    pcp_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_bstate;

    function automatic t_pos pos_inc(input t_pos p);
        pos_inc = (p == POS_W'(RING_BYTES - 1)) ? '0 : p + POS_W'(1);
    endfunction

    // Per-slot control state
    logic  r_rd_open [NUM_PIPES];
    logic  r_wr_open [NUM_PIPES];
    t_pos  r_wpos    [NUM_PIPES];
    t_pos  r_rpos    [NUM_PIPES];
    t_fill r_fill    [NUM_PIPES];

    // Ring storage
    logic [BYTE_W-1:0] r_ring [MEM_DEPTH];
    logic [BYTE_W-1:0] r_mem_q;

    // Read sequencer
    t_bstate r_state;
    t_slot   r_rslot;
    t_pos    r_rcur;
    t_len    r_cnt;

    // Result issued last cycle, completed with ring data this cycle
    logic r_pend;
    t_rsp r_pres;
    logic r_pres_rd;

    // Result queue
    t_rsp             r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wp;
    logic [OQ_AW-1:0] r_oq_rp;
    logic [OQ_CW-1:0] r_oq_cnt;

    logic                oq_pop;
    logic [OQ_CW:0]      occ;
    logic                can_issue;
    logic                idle_go;
    logic                rd_go;
    t_rsp                push_ent;
    t_slot               hs;
    logic                cur_rd;
    logic                cur_wr;
    logic                cur_busy;
    t_fill               cur_fill;
    t_pos                cur_wpos;
    t_pos                cur_rpos;
    logic                free_found;
    t_slot               free_idx;
    t_len                rd_n;
    logic [STATUS_W-1:0] res_st;
    logic [PIPE_W-1:0]   res_cp;
    logic                start_rd;
    logic                do_wr;
    logic                do_create;
    logic                do_close_rd;
    logic                do_close_wr;

    assign hs       = i_cmd.slot;
    assign cur_rd   = r_rd_open[hs];
    assign cur_wr   = r_wr_open[hs];
    assign cur_busy = cur_rd | cur_wr;
    assign cur_fill = r_fill[hs];
    assign cur_wpos = r_wpos[hs];
    assign cur_rpos = r_rpos[hs];

    // Credit check: a result issued now must find room in the queue next cycle
    assign o_rsp.valid = (r_oq_cnt != '0);
    assign oq_pop      = o_rsp.valid & o_rsp.ready;
    assign occ         = (OQ_CW+1)'(r_oq_cnt) + (OQ_CW+1)'(r_pend) - (OQ_CW+1)'(oq_pop);
    assign can_issue   = (occ < (OQ_CW+1)'(OQ_DEPTH));
    assign idle_go     = (r_state == S_IDLE) & i_cmd_valid & can_issue;
    assign rd_go       = (r_state == S_READ) & can_issue;
    assign o_cmd_ready = idle_go;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
            if (!r_rd_open[i] && !r_wr_open[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Bytes a read returns
    assign rd_n = (32'(i_cmd.len) < 32'(cur_fill)) ? i_cmd.len : LEN_W'(cur_fill);

    // Command evaluation against the addressed slot
    always_comb begin
        res_st      = ST_OK;
        res_cp      = '0;
        start_rd    = 1'b0;
        do_wr       = 1'b0;
        do_create   = 1'b0;
        do_close_rd = 1'b0;
        do_close_wr = 1'b0;
        unique case (i_cmd.kind)
            K_CREATE: begin
                if (free_found) begin
                    do_create = 1'b1;
                    res_cp    = PIPE_W'(free_idx);
                end else begin
                    res_st = ST_NONE;
                end
            end
            K_WRITE: begin
                if (!cur_busy) begin
                    res_st = ST_BAD;
                end else if (!cur_rd) begin
                    res_st = ST_BROKEN;
                end else if (32'(cur_fill) >= RING_BYTES) begin
                    res_st = ST_FULL;
                end else begin
                    do_wr = 1'b1;
                end
            end
            K_READ: begin
                if (!cur_busy) begin
                    res_st = ST_BAD;
                end else if (cur_fill == '0) begin
                    res_st = cur_wr ? ST_BLOCK : ST_EOS;
                end else begin
                    start_rd = 1'b1;
                end
            end
            K_CLOSE_RD: begin
                if (!cur_busy) res_st = ST_BAD;
                else           do_close_rd = 1'b1;
            end
            K_CLOSE_WR: begin
                if (!cur_busy) res_st = ST_BAD;
                else           do_close_wr = 1'b1;
            end
            default: res_st = ST_BAD;
        endcase
    end

    // Control state and read sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
            for (int i = 0; i < NUM_PIPES; i++) begin
                r_rd_open[i] <= 1'b0;
                r_wr_open[i] <= 1'b0;
                r_wpos[i]    <= '0;
                r_rpos[i]    <= '0;
                r_fill[i]    <= '0;
            end
        end else begin
            r_pend <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (idle_go) begin
                        if (start_rd) begin
                            r_state    <= S_READ;
                            r_rslot    <= hs;
                            r_rcur     <= cur_rpos;
                            r_cnt      <= rd_n;
                            r_fill[hs] <= cur_fill - FILL_W'(rd_n);
                        end else begin
                            r_pend    <= 1'b1;
                            r_pres    <= '{status: res_st, read_byte: '0,
                                           created_pipe: res_cp, last: 1'b1};
                            r_pres_rd <= 1'b0;
                        end
                        if (do_create) begin
                            r_rd_open[free_idx] <= 1'b1;
                            r_wr_open[free_idx] <= 1'b1;
                            r_wpos[free_idx]    <= '0;
                            r_rpos[free_idx]    <= '0;
                            r_fill[free_idx]    <= '0;
                        end
                        if (do_wr) begin
                            r_wpos[hs] <= pos_inc(cur_wpos);
                            r_fill[hs] <= cur_fill + FILL_W'(1);
                        end
                        // Last reference gone: slot returns to the free pool
                        if (do_close_rd) begin
                            r_rd_open[hs] <= 1'b0;
                            if (!cur_wr) begin
                                r_wpos[hs] <= '0;
                                r_rpos[hs] <= '0;
                                r_fill[hs] <= '0;
                            end
                        end
                        if (do_close_wr) begin
                            r_wr_open[hs] <= 1'b0;
                            if (!cur_rd) begin
                                r_wpos[hs] <= '0;
                                r_rpos[hs] <= '0;
                                r_fill[hs] <= '0;
                            end
                        end
                    end
                end
                S_READ: begin
                    if (rd_go) begin
                        r_pend          <= 1'b1;
                        r_pres          <= '{status: ST_OK, read_byte: '0,
                                             created_pipe: '0,
                                             last: (r_cnt == LEN_W'(1))};
                        r_pres_rd       <= 1'b1;
                        r_rcur          <= pos_inc(r_rcur);
                        r_rpos[r_rslot] <= pos_inc(r_rcur);
                        r_cnt           <= r_cnt - LEN_W'(1);
                        if (r_cnt == LEN_W'(1)) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (r_pend) r_oq_wp <= r_oq_wp + OQ_AW'(1);
            if (oq_pop) r_oq_rp <= r_oq_rp + OQ_AW'(1);
            r_oq_cnt <= r_oq_cnt + OQ_CW'(r_pend) - OQ_CW'(oq_pop);
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (idle_go && do_wr) r_ring[{hs, cur_wpos}] <= i_cmd.wbyte;
        if (rd_go)            r_mem_q <= r_ring[{r_rslot, r_rcur}];
    end

    // Result completion: read data joins its result here
    always_comb begin
        push_ent = r_pres;
        if (r_pres_rd) push_ent.read_byte = r_mem_q;
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) r_oq[r_oq_wp] <= push_ent;
    end

    assign o_rsp.status       = r_oq[r_oq_rp].status;
    assign o_rsp.read_byte    = r_oq[r_oq_rp].read_byte;
    assign o_rsp.created_pipe = r_oq[r_oq_rp].created_pipe;
    assign o_rsp.last         = r_oq[r_oq_rp].last;

    // Credit scheme keeps the result queue from overflowing
    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_oq_cnt != OQ_CW'(OQ_DEPTH) || oq_pop))
        else $error("result queue overflow");

    // A read in progress always has bytes left to fetch
    a_rd_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_cnt != '0))
        else $error("read sequencer running with zero count");

    // The slot being read cannot be freed under the sequencer
    a_rd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_rd_open[r_rslot] || r_wr_open[r_rslot]))
        else $error("read of a free slot");

endmodule

`default_nettype wire

// ===== rtl/pipe_channel_pool.sv =====
// Channel   Dir  Fields                                             Handshake
// i_req     in   action, pipe_index, write_byte, read_length        valid/ready
// o_rsp     out  status, read_byte, created_pipe, last              valid/ready
//
// A command waits in a two-entry queue, then the back end handles it (slot
// control read-modify-write) and registers its result for the result queue.
// A read holds the back end until all its bytes are fetched, one byte a cycle
// from the single ring memory read port while the result queue has room;
// each byte passes the ring memory read register before the result queue.
// Reset is synchronous, active low, and clears all slots at once.
// A stalled o_rsp fills a two-entry result queue, then stops the back end;
// the command queue keeps taking transactions until it is full.

`default_nettype none

module pipe_channel_pool import pcp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pcp_req_if.sink    i_req,
    pcp_rsp_if.source  o_rsp
);

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_ready;

    // Accept and decode
    pcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    // Slot state, ring memory and result path
    pcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ===== sim/pipe_pool_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the pool's results and compares them in order.
module pipe_pool_checker import pcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pcp_req_if    i_req_mon,
    pcp_rsp_if    i_rsp_mon,
    output int    o_due_count,
    output int    o_fail_count
);

    // Shadow copy of the pool
    logic [BYTE_W-1:0] ring_copy [NUM_PIPES][RING_BYTES];
    t_pos              wr_pos    [NUM_PIPES];
    t_pos              rd_pos    [NUM_PIPES];
    t_fill             fill      [NUM_PIPES];
    logic              rd_open   [NUM_PIPES];
    logic              wr_open   [NUM_PIPES];
    logic [7:0]        rd_refs   [NUM_PIPES];
    logic [7:0]        wr_refs   [NUM_PIPES];
    logic              busy      [NUM_PIPES];

    // Results still owed by the block, oldest first
    t_rsp rsp_due [$];
    int   mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // One line per mismatch; printing is capped, counting is not
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Applies one request transaction to the shadow pool and queues its results
    function automatic void predict_results(input logic [ACTION_W-1:0] act,
                                            input logic [PIPE_W-1:0]   idx,
                                            input logic [BYTE_W-1:0]   wbyte,
                                            input logic [RLEN_W-1:0]   rlen);
        t_rsp r;
        int   s;
        int   lim;
        int   n;
        logic found;
        r      = '0;
        r.last = 1'b1;
        s      = int'(idx);
        found  = 1'b0;

        if (act == ACT_CREATE) begin
            for (int i = 0; i < NUM_PIPES; i++) begin
                if (!busy[i] && !found) begin
                    found          = 1'b1;
                    wr_pos[i]      = '0;
                    rd_pos[i]      = '0;
                    fill[i]        = '0;
                    rd_open[i]     = 1'b1;
                    wr_open[i]     = 1'b1;
                    rd_refs[i]     = 8'd1;
                    wr_refs[i]     = 8'd1;
                    busy[i]        = 1'b1;
                    r.created_pipe = PIPE_W'(i);
                end
            end
            r.status = found ? ST_OK : ST_NONE;
            rsp_due.push_back(r);
            return;
        end

        // Unknown action or free slot
        if (act > ACT_CLOSE_WR || s >= NUM_PIPES || !busy[s]) begin
            r.status = ST_BAD;
            rsp_due.push_back(r);
            return;
        end

        case (act)
            ACT_WRITE: begin
                if (!rd_open[s]) begin
                    r.status = ST_BROKEN;
                end else if (int'(fill[s]) >= RING_BYTES) begin
                    r.status = ST_FULL;
                end else begin
                    ring_copy[s][wr_pos[s]] = wbyte;
                    wr_pos[s] = t_pos'((int'(wr_pos[s]) + 1) % RING_BYTES);
                    fill[s]   = fill[s] + 1'b1;
                    r.status  = ST_OK;
                end
                rsp_due.push_back(r);
            end
            ACT_READ: begin
                if (fill[s] == '0) begin
                    r.status = wr_open[s] ? ST_BLOCK : ST_EOS;
                    rsp_due.push_back(r);
                end else begin
                    // zero length acts as one, long lengths saturate
                    lim = (rlen == '0) ? 1 : int'(rlen);
                    if (lim > MAX_READ) lim = MAX_READ;
                    n = (lim < int'(fill[s])) ? lim : int'(fill[s]);
                    for (int k = 0; k < n; k++) begin
                        r.status    = ST_OK;
                        r.read_byte = ring_copy[s][rd_pos[s]];
                        r.last      = (k == n - 1);
                        rsp_due.push_back(r);
                        rd_pos[s] = t_pos'((int'(rd_pos[s]) + 1) % RING_BYTES);
                    end
                    fill[s] = fill[s] - t_fill'(n);
                end
            end
            default: begin
                // close reader or writer; a count at zero stays there
                if (act == ACT_CLOSE_WR) begin
                    if (wr_refs[s] != 0) wr_refs[s] = wr_refs[s] - 1'b1;
                    if (wr_refs[s] == 0) wr_open[s] = 1'b0;
                end else begin
                    if (rd_refs[s] != 0) rd_refs[s] = rd_refs[s] - 1'b1;
                    if (rd_refs[s] == 0) rd_open[s] = 1'b0;
                end
                if (rd_refs[s] == 0 && wr_refs[s] == 0) begin
                    busy[s]   = 1'b0;
                    fill[s]   = '0;
                    wr_pos[s] = '0;
                    rd_pos[s] = '0;
                end
                r.status = ST_OK;
                rsp_due.push_back(r);
            end
        endcase
    endfunction

    // Predict on request transactions, compare on result transactions
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PIPES; i++) begin
                wr_pos[i]  = '0;
                rd_pos[i]  = '0;
                fill[i]    = '0;
                rd_open[i] = 1'b0;
                wr_open[i] = 1'b0;
                rd_refs[i] = '0;
                wr_refs[i] = '0;
                busy[i]    = 1'b0;
            end
            rsp_due.delete();
        end else begin
            if (i_req_mon.valid && i_req_mon.ready) begin
                predict_results(i_req_mon.action, i_req_mon.pipe_index,
                                i_req_mon.write_byte, i_req_mon.read_length);
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (rsp_due.size() == 0) begin
                    report_mismatch("result with none pending, status",
                                    int'(i_rsp_mon.status), -1);
                end else begin
                    want = rsp_due.pop_front();
                    if (i_rsp_mon.status !== want.status)
                        report_mismatch("status", int'(i_rsp_mon.status), int'(want.status));
                    if (i_rsp_mon.read_byte !== want.read_byte)
                        report_mismatch("read_byte", int'(i_rsp_mon.read_byte),
                                        int'(want.read_byte));
                    if (i_rsp_mon.created_pipe !== want.created_pipe)
                        report_mismatch("created_pipe", int'(i_rsp_mon.created_pipe),
                                        int'(want.created_pipe));
                    if (i_rsp_mon.last !== want.last)
                        report_mismatch("last", int'(i_rsp_mon.last), int'(want.last));
                end
            end
        end
        o_due_count <= rsp_due.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pcp_pkg::*;

    // Cycles with no transaction on either channel before the run is called hung;
    // the worst honest stretch is one ready stall plus the pool's latency.
    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 50;
    localparam int CALM_TAIL    = 15;
    localparam int DRAIN_CYCLES = 20;
    localparam int CAP_WRITES   = 6;

    localparam logic [ACTION_W-1:0] ACT_RESERVED_LO = ACT_CLOSE_WR + 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RESERVED_HI = '1;
    localparam logic [RLEN_W-1:0]   RLEN_TOP        = '1;
    localparam logic [PIPE_W-1:0]   LAST_PIPE       = PIPE_W'(NUM_PIPES - 1);

    logic clk;
    logic rst_n;
    bit   send_gaps;
    bit   recv_gaps;
    int   stall_left;
    int   idle_cycles;
    int   due_count;
    int   fail_count;

    // Which slots the stimulus believes are open, to aim at live pipes
    logic pipe_live [NUM_PIPES];
    logic rd_live   [NUM_PIPES];
    logic wr_live   [NUM_PIPES];

    pcp_req_if req_bus ();
    pcp_rsp_if rsp_bus ();

    pipe_channel_pool u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    pipe_pool_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_mon    (req_bus),
        .i_rsp_mon    (rsp_bus),
        .o_due_count  (due_count),
        .o_fail_count (fail_count)
    );

    // 12 ns clock
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side: ready drops in bursts of random length
    always @(negedge clk) begin
        if (recv_gaps && stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("pipe_channel_pool regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one request transaction, with an optional gap in front
    task automatic issue_action(input logic [ACTION_W-1:0] act,
                                input logic [PIPE_W-1:0]   idx,
                                input logic [BYTE_W-1:0]   wbyte,
                                input logic [RLEN_W-1:0]   rlen);
        int gap;
        int s;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_bus.valid       <= 1'b1;
        req_bus.action      <= act;
        req_bus.pipe_index  <= idx;
        req_bus.write_byte  <= wbyte;
        req_bus.read_length <= rlen;
        do @(posedge clk); while (!req_bus.ready);

        // track slot ownership for aiming later transactions
        case (act)
            ACT_CREATE: begin
                s = -1;
                for (int i = NUM_PIPES - 1; i >= 0; i--) if (!pipe_live[i]) s = i;
                if (s >= 0) begin
                    pipe_live[s] = 1'b1;
                    rd_live[s]   = 1'b1;
                    wr_live[s]   = 1'b1;
                end
            end
            ACT_CLOSE_RD: if (pipe_live[idx]) begin
                rd_live[idx] = 1'b0;
                if (!wr_live[idx]) pipe_live[idx] = 1'b0;
            end
            ACT_CLOSE_WR: if (pipe_live[idx]) begin
                wr_live[idx] = 1'b0;
                if (!rd_live[idx]) pipe_live[idx] = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Stop sending and wait for every owed result
    task automatic quiesce();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        wait (due_count == 0);
    endtask

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < NUM_PIPES; i++) if (pipe_live[i]) n++;
        return n;
    endfunction

    // Random open pipe, or any slot when none is open
    function automatic logic [PIPE_W-1:0] pick_live_pipe();
        int k;
        logic [PIPE_W-1:0] sel;
        sel = PIPE_W'($urandom_range(0, NUM_PIPES - 1));
        if (live_count() > 0) begin
            k = $urandom_range(0, live_count() - 1);
            for (int i = 0; i < NUM_PIPES; i++) begin
                if (pipe_live[i]) begin
                    if (k == 0) sel = PIPE_W'(i);
                    k--;
                end
            end
        end
        return sel;
    endfunction

    // Mostly short reads, sometimes zero, the maximum or beyond it
    function automatic logic [RLEN_W-1:0] pick_read_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RLEN_W'(MAX_READ);
            2:       return RLEN_W'($urandom_range(MAX_READ + 1, int'(RLEN_TOP)));
            default: return RLEN_W'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin
        int roll;
        logic [PIPE_W-1:0] p;

        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.action      = '0;
        req_bus.pipe_index  = '0;
        req_bus.write_byte  = '0;
        req_bus.read_length = '0;
        rsp_bus.ready       = 1'b0;
        idle_cycles         = 0;
        stall_left          = 0;
        send_gaps           = 1'b1;
        recv_gaps           = 1'b1;
        for (int i = 0; i < NUM_PIPES; i++) begin
            pipe_live[i] = 1'b0;
            rd_live[i]   = 1'b0;
            wr_live[i]   = 1'b0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: bad slots, unknown actions, open/close sequences, length edges
        issue_action(ACT_READ, 4'd0, 8'h00, 7'd1);
        issue_action(ACT_WRITE, LAST_PIPE, 8'hFF, 7'd1);
        issue_action(ACT_CLOSE_RD, 4'd9, 8'h00, 7'd1);
        issue_action(ACT_RESERVED_LO, 4'd0, 8'h00, 7'd1);
        issue_action(ACT_RESERVED_HI, LAST_PIPE, 8'hFF, RLEN_TOP);
        issue_action(ACT_CREATE, LAST_PIPE, 8'hFF, RLEN_TOP);
        issue_action(ACT_CREATE, 4'd0, 8'h00, 7'd0);
        issue_action(ACT_READ, 4'd0, 8'h00, 7'd1);
        issue_action(ACT_WRITE, 4'd0, 8'h00, 7'd1);
        issue_action(ACT_WRITE, 4'd0, 8'hFF, 7'd1);
        issue_action(ACT_WRITE, 4'd0, 8'h5A, 7'd1);
        issue_action(ACT_CLOSE_RD, 4'd0, 8'h00, 7'd1);
        issue_action(ACT_WRITE, 4'd0, 8'hC3, 7'd1);
        issue_action(ACT_READ, 4'd0, 8'h00, 7'd0);
        issue_action(ACT_READ, 4'd0, 8'h00, RLEN_TOP);
        issue_action(ACT_READ, 4'd0, 8'h00, 7'd1);
        issue_action(ACT_CLOSE_WR, 4'd0, 8'h00, 7'd1);
        issue_action(ACT_READ, 4'd0, 8'h00, 7'd1);
        issue_action(ACT_CLOSE_WR, 4'd1, 8'h00, 7'd1);
        issue_action(ACT_READ, 4'd1, 8'h00, 7'd1);
        issue_action(ACT_WRITE, 4'd1, 8'h81, 7'd1);
        issue_action(ACT_READ, 4'd1, 8'h00, RLEN_W'(MAX_READ));
        issue_action(ACT_CLOSE_WR, 4'd1, 8'h00, 7'd1);
        issue_action(ACT_CLOSE_RD, 4'd1, 8'h00, 7'd1);
        quiesce();

        // Capacity: exhaust the pool, then a short burst of writes and one read
        send_gaps = 1'b0;
        repeat (NUM_PIPES + 1) issue_action(ACT_CREATE, 4'd0, 8'h00, 7'd1);
        repeat (CAP_WRITES) issue_action(ACT_WRITE, LAST_PIPE, 8'($urandom), 7'd1);
        issue_action(ACT_READ, LAST_PIPE, 8'h00, RLEN_TOP);
        for (int i = 0; i < NUM_PIPES; i++) begin
            issue_action(ACT_CLOSE_RD, PIPE_W'(i), 8'h00, 7'd1);
            issue_action(ACT_CLOSE_WR, PIPE_W'(i), 8'h00, 7'd1);
        end
        quiesce();

        // Random traffic aimed mostly at open pipes, with some noise
        send_gaps = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_TAIL) begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            roll = $urandom_range(0, 99);
            p    = pick_live_pipe();
            if (live_count() == 0 || roll < 10)
                issue_action(ACT_CREATE, 4'($urandom), 8'($urandom), 7'($urandom));
            else if (roll < 45)
                issue_action(ACT_WRITE, p, 8'($urandom), 7'($urandom));
            else if (roll < 75)
                issue_action(ACT_READ, p, 8'($urandom), pick_read_length());
            else if (roll < 83)
                issue_action(ACT_CLOSE_RD, p, 8'($urandom), 7'($urandom));
            else if (roll < 91)
                issue_action(ACT_CLOSE_WR, p, 8'($urandom), 7'($urandom));
            else if (roll < 96)
                issue_action(3'($urandom_range(0, int'(ACT_CLOSE_WR))), 4'($urandom),
                             8'($urandom), 7'($urandom));
            else
                issue_action(3'($urandom_range(int'(ACT_RESERVED_LO), int'(ACT_RESERVED_HI))),
                             4'($urandom), 8'($urandom), 7'($urandom));
        end
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("pipe_channel_pool regression: pass");
        end else begin
            $display("pipe_channel_pool regression: fail");
        end
        $finish;
    end

endmodule
